@@ rtl/hfrf_pkg.sv @@
// hfrf_pkg: shared widths, codes and controller/datapath interface structs
// for the heap free-run finder; no dependencies
package hfrf_pkg;

   localparam int MAP_ENTRIES_DEF = 2048;

   localparam int OP_W       = 1;
   localparam int IDX_W      = 11;
   localparam int VAL_W      = 4;
   localparam int SIZE_W     = 12;
   localparam int ADDR_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
   localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_STRATEGY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USED     = 2'd2;

   localparam logic [SIZE_W-1:0] USED_RESET = 12'd2048;

   typedef enum logic [1:0] {
      STRAT_FIRST = 2'd0,
      STRAT_NEXT  = 2'd1,
      STRAT_BEST  = 2'd2,
      STRAT_WORST = 2'd3
   } strategy_type;

   typedef struct packed {
      logic clear_step;
      logic map_write;
      logic scan_init;
      logic load_size;
      logic from_start;
      logic scan_step;
      logic load_rsp;
   } hfrf_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_done;
      logic have;
      logic next_fit;
   } hfrf_status_type;

endpackage

@@ rtl/hfrf_datapath.sv @@
// hfrf_datapath: allocation map memory, configuration registers, run scanner
// and result register; uses hfrf_pkg, driven by hfrf_controller
module hfrf_datapath #(
   parameter int MAP_ENTRIES = hfrf_pkg::MAP_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [hfrf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hfrf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [hfrf_pkg::IDX_W-1:0]          req_entry_index,
   input  logic [hfrf_pkg::VAL_W-1:0]          req_entry_value,
   input  logic [hfrf_pkg::SIZE_W-1:0]         req_request_size,
   input  hfrf_pkg::hfrf_cmd_type              cmd,
   output hfrf_pkg::hfrf_status_type           status,
   output logic                                rsp_found,
   output logic [hfrf_pkg::ADDR_W-1:0]         rsp_address
);

   localparam int OFF_W = $clog2(MAP_ENTRIES);
   localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
   localparam int LEN_W = (CNT_W > hfrf_pkg::SIZE_W) ? CNT_W : hfrf_pkg::SIZE_W;

   // configuration
   hfrf_pkg::strategy_type              strategy_ff;
   logic [hfrf_pkg::ADDR_W-1:0]         base_ff;
   logic [hfrf_pkg::SIZE_W-1:0]         used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= hfrf_pkg::STRAT_FIRST;
         base_ff     <= '0;
         used_ff     <= hfrf_pkg::USED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hfrf_pkg::CSR_STRATEGY: strategy_ff <= hfrf_pkg::strategy_type'(csr_wdata[1:0]);
            hfrf_pkg::CSR_BASE:     base_ff     <= csr_wdata;
            hfrf_pkg::CSR_USED:     used_ff     <= csr_wdata[hfrf_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0] lim;
   assign lim = (32'(used_ff) > 32'(MAP_ENTRIES)) ? CNT_W'(MAP_ENTRIES) : CNT_W'(used_ff);

   // map memory
   logic [hfrf_pkg::VAL_W-1:0] map_mem [MAP_ENTRIES];
   logic [OFF_W-1:0]           clr_ff, clr_in;
   logic                       mem_we;
   logic [OFF_W-1:0]           mem_waddr;
   logic [hfrf_pkg::VAL_W-1:0] mem_wdata;
   logic [hfrf_pkg::VAL_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]           addr_ff, addr_in;
   logic                       write_ok;

   assign write_ok  = 32'(req_entry_index) < 32'(MAP_ENTRIES);
   assign mem_we    = cmd.clear_step || (cmd.map_write && write_ok);
   assign mem_waddr = cmd.clear_step ? clr_ff : OFF_W'(req_entry_index);
   assign mem_wdata = cmd.clear_step ? '0 : req_entry_value;
   assign clr_in    = cmd.clear_step ? clr_ff + OFF_W'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[addr_ff[OFF_W-1:0]];
   end

   // scan state
   logic                       dv_ff, dv_in;
   logic [OFF_W-1:0]           idx_ff, idx_in;
   logic [hfrf_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0]           run_len_ff, run_len_in;
   logic [OFF_W-1:0]           run_start_ff, run_start_in;
   logic                       have_ff, have_in;
   logic [CNT_W-1:0]           pick_len_ff, pick_len_in;
   logic [OFF_W-1:0]           pick_off_ff, pick_off_in;
   logic [OFF_W-1:0]           next_start_ff, next_start_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [hfrf_pkg::ADDR_W-1:0] rsp_address_ff, rsp_address_in;

   logic             issue;
   logic             in_range;
   logic             free;
   logic             last;
   logic             cand_valid;
   logic [CNT_W-1:0] cand_len;
   logic [OFF_W-1:0] cand_start;
   logic             fits;
   logic             better;
   logic             take;

   assign in_range = addr_ff < lim;
   assign issue    = cmd.scan_step && in_range && !cmd.scan_init;

   always_comb begin
      free       = (rd_data_ff == '0);
      last       = (CNT_W'(idx_ff) + CNT_W'(1)) == lim;
      cand_start = (run_len_ff == '0) ? idx_ff : run_start_ff;
      cand_len   = free ? run_len_ff + CNT_W'(1) : run_len_ff;
      if (!free) begin
         cand_start = run_start_ff;
      end
      cand_valid = dv_ff && (free ? last : (run_len_ff != '0));
      fits       = LEN_W'(cand_len) >= LEN_W'(size_ff);
      case (strategy_ff)
         hfrf_pkg::STRAT_BEST:  better = !have_ff || (cand_len < pick_len_ff);
         hfrf_pkg::STRAT_WORST: better = !have_ff || (cand_len > pick_len_ff);
         default:               better = !have_ff;
      endcase
      take = cand_valid && fits && better;

      addr_in      = addr_ff;
      dv_in        = issue;
      idx_in       = issue ? addr_ff[OFF_W-1:0] : idx_ff;
      size_in      = cmd.load_size ? req_request_size : size_ff;
      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      have_in      = have_ff;
      pick_len_in  = pick_len_ff;
      pick_off_in  = pick_off_ff;

      if (cmd.scan_init) begin
         addr_in      = cmd.from_start ? CNT_W'(next_start_ff) : '0;
         run_len_in   = '0;
         run_start_in = '0;
         have_in      = 1'b0;
         pick_len_in  = '0;
         pick_off_in  = '0;
      end else begin
         if (issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
         if (dv_ff) begin
            if (free) begin
               run_len_in   = run_len_ff + CNT_W'(1);
               run_start_in = (run_len_ff == '0) ? idx_ff : run_start_ff;
            end else begin
               run_len_in = '0;
            end
         end
         if (take) begin
            have_in     = 1'b1;
            pick_len_in = cand_len;
            pick_off_in = cand_start;
         end
      end

      next_start_in  = next_start_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_address_in = rsp_address_ff;
      if (cmd.load_rsp) begin
         rsp_found_in   = have_ff;
         rsp_address_in = have_ff ? base_ff + hfrf_pkg::ADDR_W'(pick_off_ff) : '0;
         if (have_ff && (strategy_ff == hfrf_pkg::STRAT_NEXT)) begin
            next_start_in = pick_off_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         dv_ff         <= 1'b0;
         have_ff       <= 1'b0;
         next_start_ff <= '0;
         addr_ff       <= '0;
      end else begin
         clr_ff        <= clr_in;
         dv_ff         <= dv_in;
         have_ff       <= have_in;
         next_start_ff <= next_start_in;
         addr_ff       <= addr_in;
      end
      idx_ff         <= idx_in;
      size_ff        <= size_in;
      run_len_ff     <= run_len_in;
      run_start_ff   <= run_start_in;
      pick_len_ff    <= pick_len_in;
      pick_off_ff    <= pick_off_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_address_ff <= rsp_address_in;
   end

   assign status.clear_last = (clr_ff == OFF_W'(MAP_ENTRIES - 1));
   assign status.scan_done  = !in_range && !dv_ff;
   assign status.have       = have_ff;
   assign status.next_fit   = (strategy_ff == hfrf_pkg::STRAT_NEXT);

   assign rsp_found   = rsp_found_ff;
   assign rsp_address = rsp_address_ff;

endmodule

@@ rtl/hfrf_controller.sv @@
// hfrf_controller: sequencer for map clearing, writes, scans and result hand-off
// uses hfrf_pkg command and status structs
module hfrf_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [hfrf_pkg::OP_W-1:0]   req_op,
   input  logic                        size_zero,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  hfrf_pkg::hfrf_status_type   status,
   output hfrf_pkg::hfrf_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN1,
      S_SCAN2,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == hfrf_pkg::OP_WRITE) begin
                  cmd.map_write = 1'b1;
               end else begin
                  cmd.scan_init  = 1'b1;
                  cmd.load_size  = 1'b1;
                  cmd.from_start = status.next_fit;
                  state_in       = size_zero ? S_FINISH : S_SCAN1;
               end
            end
         end
         S_SCAN1: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               if (status.next_fit && !status.have) begin
                  // wrap around: retry from the start of the map
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN2;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN2: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/heap_free_run_finder.sv @@
// heap_free_run_finder: top level, free-run search over a heap allocation map
// depends on hfrf_pkg, hfrf_controller and hfrf_datapath
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_ready  op, entry_index, entry_value, request_size
//   rsp_         out         rsp_valid/rsp_ready  found, address
//   csr_         in          csr_we               csr_index, csr_wdata
//
// after reset a clearing pass zeroes the map while req_ready is low
// a search reads one map entry per cycle from the single map read port, from
// the start offset up to the used entries; a next fit miss rescans from the map
// start; a zero size search skips the scan
// a finished result waits in the output register; the next beat is taken meanwhile
module heap_free_run_finder #(
   parameter int MAP_ENTRIES = hfrf_pkg::MAP_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [hfrf_pkg::OP_W-1:0]       req_op,
   input  logic [hfrf_pkg::IDX_W-1:0]      req_entry_index,
   input  logic [hfrf_pkg::VAL_W-1:0]      req_entry_value,
   input  logic [hfrf_pkg::SIZE_W-1:0]     req_request_size,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [hfrf_pkg::ADDR_W-1:0]     rsp_address,
   input  logic                            csr_we,
   input  logic [hfrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hfrf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   hfrf_pkg::hfrf_cmd_type    cmd;
   hfrf_pkg::hfrf_status_type status;

   hfrf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .size_zero (req_request_size == '0),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hfrf_datapath #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_request_size (req_request_size),
      .cmd              (cmd),
      .status           (status),
      .rsp_found        (rsp_found),
      .rsp_address      (rsp_address)
   );

   // a write beat never raises a result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == hfrf_pkg::OP_WRITE) && !rsp_valid) |=> !rsp_valid)
      else $error("result raised by a map write");

   // the result register is never overwritten while a result waits
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   // a miss carries a zero address
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_address == '0))
      else $error("miss with nonzero address");

   // the clearing pass owns the map write port
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> (!cmd.map_write && !cmd.scan_step && !req_ready))
      else $error("map access during clearing pass");

endmodule

@@ dv/hfrf_grant_checker.sv @@
// hfrf_grant_checker: watches the request, result and register ports of the
// heap free-run finder, predicts each search grant and compares it
// depends on hfrf_pkg
module hfrf_grant_checker
   import hfrf_pkg::*;
#(
   parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [IDX_W-1:0]      req_entry_index,
   input  logic [VAL_W-1:0]      req_entry_value,
   input  logic [SIZE_W-1:0]     req_request_size,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_found,
   input  logic [ADDR_W-1:0]     rsp_address,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    grants_owed,
   output int                    mismatches
);

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] address;
   } grant_type;

   logic [VAL_W-1:0]  heap_map [MAP_ENTRIES];
   logic [IDX_W-1:0]  next_start;
   strategy_type      heap_strategy;
   logic [ADDR_W-1:0] heap_base;
   logic [SIZE_W-1:0] heap_used;
   grant_type         expected_grants [$];
   int                grants_seen;

   function automatic bit find_free_run(input int from, input int size,
                                        input strategy_type how, output int offset);
      int limit;
      int i;
      int run_start;
      int run_len;
      int pick_len;
      bit have;
      limit = (heap_used > MAP_ENTRIES) ? MAP_ENTRIES : heap_used;
      i = from;
      have = 1'b0;
      pick_len = 0;
      offset = 0;
      while (i < limit) begin
         if (heap_map[i] != '0) begin
            i++;
         end else begin
            run_start = i;
            while (i < limit && heap_map[i] == '0) i++;
            run_len = i - run_start;
            if (run_len >= size) begin
               if (how == STRAT_FIRST || how == STRAT_NEXT) begin
                  offset = run_start;
                  return 1'b1;
               end
               if (!have || (how == STRAT_BEST ? run_len < pick_len : run_len > pick_len)) begin
                  have = 1'b1;
                  pick_len = run_len;
                  offset = run_start;
               end
            end
         end
      end
      return have;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      int offset;
      bit hit;
      if (reset) begin
         foreach (heap_map[k]) heap_map[k] = '0;
         next_start = '0;
         heap_strategy = STRAT_FIRST;
         heap_base = '0;
         heap_used = USED_RESET;
         expected_grants.delete();
         grants_seen = 0;
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            grants_seen++;
            if (expected_grants.size() == 0) begin
               if (mismatches < 10)
                  $display("grant %0d unexpected: found %0b address %h",
                           grants_seen, rsp_found, rsp_address);
               mismatches++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_found !== want.found || rsp_address !== want.address) begin
                  if (mismatches < 10)
                     $display("grant %0d: found exp %0b got %0b, address exp %h got %h",
                              grants_seen, want.found, rsp_found, want.address, rsp_address);
                  mismatches++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_STRATEGY: heap_strategy = strategy_type'(csr_wdata[1:0]);
               CSR_BASE:     heap_base = csr_wdata[ADDR_W-1:0];
               CSR_USED:     heap_used = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_WRITE) begin
               heap_map[req_entry_index] = req_entry_value;
            end else begin
               hit = 1'b0;
               offset = 0;
               if (req_request_size != '0) begin
                  if (heap_strategy == STRAT_NEXT) begin
                     hit = find_free_run(next_start, req_request_size, STRAT_NEXT, offset);
                     if (!hit) hit = find_free_run(0, req_request_size, STRAT_NEXT, offset);
                     if (hit) next_start = IDX_W'(offset);
                  end else begin
                     hit = find_free_run(0, req_request_size, heap_strategy, offset);
                  end
               end
               want.found = hit;
               want.address = hit ? ADDR_W'(heap_base + offset) : '0;
               expected_grants.push_back(want);
            end
         end
      end
      grants_owed <= expected_grants.size();
   end

endmodule

@@ dv/tb.sv @@
// tb: stimulus and verdict for heap_free_run_finder, with directed and random
// map writes and searches under every strategy and several register settings
// depends on hfrf_pkg, heap_free_run_finder and hfrf_grant_checker
module tb;
   import hfrf_pkg::*;

   localparam int MAP_N = MAP_ENTRIES_DEF;
   localparam int STALL_MAX = 13;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op;
   logic [IDX_W-1:0]      req_entry_index;
   logic [VAL_W-1:0]      req_entry_value;
   logic [SIZE_W-1:0]     req_request_size;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_found;
   logic [ADDR_W-1:0]     rsp_address;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    grants_owed;
   int                    mismatches;

   int beats_sent;
   int heap_span;
   int sender_calm;
   int receiver_calm;
   int idle_cycles;

   heap_free_run_finder dut (.*);

   hfrf_grant_checker grant_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(6, 24);
         return 0;
      end
      return $urandom_range(0, STALL_MAX);
   endfunction

   function automatic int pick_size(input int room);
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 4095);
         1, 2:    return $urandom_range(1, room);
         default: return $urandom_range(1, (room < 8) ? room : 8);
      endcase
   endfunction

   // write: arg_a index, arg_b value; search: arg_a size
   task automatic send_beat(input logic [OP_W-1:0] op, input int arg_a, input int arg_b);
      int gap;
      gap = draw_gap(sender_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      if (op == OP_WRITE) begin
         req_entry_index <= IDX_W'(arg_a);
         req_entry_value <= VAL_W'(arg_b);
         req_request_size <= SIZE_W'($urandom);
      end else begin
         req_request_size <= SIZE_W'(arg_a);
         req_entry_index <= IDX_W'($urandom);
         req_entry_value <= VAL_W'($urandom);
      end
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic program_heap(input strategy_type how, input int base, input int used);
      req_valid <= 1'b0;
      do @(posedge clock); while (grants_owed != 0);
      // a map write may still be in flight
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_STRATEGY;
      csr_wdata <= {14'($urandom), how};
      @(posedge clock);
      csr_index <= CSR_BASE;
      csr_wdata <= CSR_DATA_W'(base);
      @(posedge clock);
      csr_index <= CSR_USED;
      csr_wdata <= {4'($urandom), SIZE_W'(used)};
      @(posedge clock);
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      heap_span = used;
   endtask

   task automatic random_phase(input int beats);
      int stop;
      int start;
      int len;
      int fill;
      int k;
      int room;
      stop = beats_sent + beats;
      room = (heap_span == 0) ? 16 : ((heap_span > MAP_N) ? MAP_N : heap_span);
      while (beats_sent < stop) begin
         start = $urandom_range(0, room - 1);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               len = $urandom_range(1, 8);
               fill = $urandom_range(1, 15);
               for (k = start; k < start + len && k < MAP_N; k++)
                  send_beat(OP_WRITE, k, fill);
               repeat ($urandom_range(1, 3)) send_beat(OP_SEARCH, pick_size(room), 0);
            end
            5, 6, 7: begin
               len = $urandom_range(1, 16);
               for (k = start; k < start + len && k < MAP_N; k++)
                  send_beat(OP_WRITE, k, 0);
               send_beat(OP_SEARCH, pick_size(room), 0);
            end
            default: begin
               if ($urandom_range(0, 1) == 0)
                  send_beat(OP_WRITE, $urandom_range(0, MAP_N - 1), $urandom_range(0, 15));
               else
                  send_beat(OP_SEARCH, $urandom_range(0, 4095), 0);
            end
         endcase
      end
   endtask

   initial begin
      int gap;
      rsp_ready = 1'b0;
      receiver_calm = 0;
      forever begin
         gap = draw_gap(receiver_calm);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int phase;
      int span;
      int base;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_WRITE;
      req_entry_index = '0;
      req_entry_value = '0;
      req_request_size = '0;
      csr_we = 1'b0;
      csr_index = CSR_STRATEGY;
      csr_wdata = '0;
      beats_sent = 0;
      heap_span = MAP_N;
      sender_calm = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first fit over the whole cleared map
      send_beat(OP_SEARCH, 0, 0);
      send_beat(OP_SEARCH, 1, 0);
      send_beat(OP_SEARCH, MAP_N, 0);
      send_beat(OP_SEARCH, MAP_N + 1, 0);
      send_beat(OP_SEARCH, 4095, 0);
      send_beat(OP_WRITE, 0, 15);
      send_beat(OP_WRITE, MAP_N - 1, 1);
      send_beat(OP_WRITE, 5, 8);
      send_beat(OP_SEARCH, 4, 0);
      send_beat(OP_SEARCH, 2041, 0);
      send_beat(OP_SEARCH, 2042, 0);

      // next fit, range clamped to the map, address wraps
      program_heap(STRAT_NEXT, 16'hfff0, 12'hfff);
      send_beat(OP_SEARCH, 20, 0);
      send_beat(OP_WRITE, 30, 3);
      send_beat(OP_SEARCH, 1500, 0);
      // stored start now beyond the range
      program_heap(STRAT_NEXT, 16'hfff0, 20);
      send_beat(OP_SEARCH, 2, 0);
      send_beat(OP_SEARCH, 0, 0);
      program_heap(STRAT_NEXT, 0, 0);
      send_beat(OP_SEARCH, 1, 0);
      program_heap(STRAT_BEST, 16'h1234, MAP_N);
      send_beat(OP_SEARCH, 3, 0);
      program_heap(STRAT_WORST, 16'hffff, MAP_N);
      send_beat(OP_SEARCH, 3, 0);

      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            1:       span = MAP_N;
            6:       span = 0;
            7:       span = 4095;
            default: span = $urandom_range(2, 80);
         endcase
         case (phase)
            2:       base = 16'hffff;
            5:       base = 0;
            default: base = $urandom_range(0, 65535);
         endcase
         program_heap(strategy_type'(phase % 4), base, span);
         random_phase(26);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (grants_owed != 0);
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/hfrf_pkg.sv
rtl/hfrf_datapath.sv
rtl/hfrf_controller.sv
rtl/heap_free_run_finder.sv
dv/hfrf_grant_checker.sv
dv/tb.sv
